FILE: rtl/isphp_pkg.sv
// Shared types and constants for the iron setpoint, idle timer and heater PWM block.
// No dependencies; every other file in rtl/ but isphp_if refers to this package by scoped names.
package isphp_pkg;

  // Event codes carried in func
  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_WAKE    = 3'd1;
  localparam logic [2:0] FUNC_UP      = 3'd2;
  localparam logic [2:0] FUNC_DOWN    = 3'd3;
  localparam logic [2:0] FUNC_PWM     = 3'd4;
  localparam logic [2:0] FUNC_MEASURE = 3'd5;

  // Idle mode codes
  localparam logic [1:0] MODE_ACTIVE  = 2'd0;
  localparam logic [1:0] MODE_STANDBY = 2'd1;
  localparam logic [1:0] MODE_OFF     = 2'd2;

  // Register map (index = paddr[4:2])
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_START_SETPOINT  = 3'd0;
  localparam logic [2:0] REG_STANDBY_TEMP    = 3'd1;
  localparam logic [2:0] REG_MAX_SETPOINT    = 3'd2;
  localparam logic [2:0] REG_STANDBY_SECONDS = 3'd3;
  localparam logic [2:0] REG_OFF_SECONDS     = 3'd4;
  localparam logic [2:0] REG_READY_BAND      = 3'd5;
  localparam logic [2:0] REG_PWM_PERIOD      = 3'd6;

  // Register reset values
  localparam logic [8:0]  RST_START_SETPOINT  = 9'd180;
  localparam logic [8:0]  RST_STANDBY_TEMP    = 9'd180;
  localparam logic [8:0]  RST_MAX_SETPOINT    = 9'd500;
  localparam logic [11:0] RST_STANDBY_SECONDS = 12'd600;
  localparam logic [11:0] RST_OFF_SECONDS     = 12'd1800;
  localparam logic [7:0]  RST_READY_BAND      = 8'd10;
  localparam logic [7:0]  RST_PWM_PERIOD      = 8'd100;

  // Pulse width shaping
  localparam logic [5:0] DUTY_MIN      = 6'd4;
  localparam logic [5:0] DUTY_MAX      = 6'd40;
  localparam logic [5:0] DUTY_OFFSET   = 6'd5;
  localparam logic [9:0] GAP_FULL_ON   = 10'd20;

  typedef struct packed {
    logic [8:0]  start_setpoint;
    logic [8:0]  standby_temp;
    logic [8:0]  max_setpoint;
    logic [11:0] standby_seconds;
    logic [11:0] off_seconds;
    logic [7:0]  ready_band;
    logic [7:0]  pwm_period;
  } cfg_t;

  // Target load caused by a start_setpoint write
  typedef struct packed {
    logic       load;
    logic [8:0] value;
  } tgt_load_t;

  typedef struct packed {
    logic [2:0] func;
    logic [9:0] measured_temp;
    logic       measured_valid;
  } evt_t;

  typedef struct packed {
    logic [8:0]  target;
    logic [8:0]  saved_target;
    logic [11:0] idle_count;
    logic        timer_running;
    logic [7:0]  pwm_phase;
    logic [9:0]  tip_temp;
    logic        drive;
  } state_t;

  typedef struct packed {
    logic [8:0] setpoint;
    logic       heater_on;
    logic       ready_res;
    logic [1:0] idle_mode;
    logic       setpoint_changed;
    logic [5:0] duty;
  } res_t;

endpackage

FILE: rtl/isphp_if.sv
// Request and result channel interfaces (valid/ready handshake with payload).
// Depends on nothing; used by the top level of the block.
interface isphp_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [9:0] measured_temp;
  logic       measured_valid;

  modport source (output valid, func, measured_temp, measured_valid, input ready);
  modport sink (input valid, func, measured_temp, measured_valid, output ready);
endinterface

interface isphp_res_if;
  logic       valid;
  logic       ready;
  logic [8:0] setpoint;
  logic       heater_on;
  logic       ready_res;
  logic [1:0] idle_mode;
  logic       setpoint_changed;
  logic [5:0] duty;

  modport source (output valid, setpoint, heater_on, ready_res, idle_mode, setpoint_changed,
                  duty, input ready);
  modport sink (input valid, setpoint, heater_on, ready_res, idle_mode, setpoint_changed,
                duty, output ready);
endinterface

FILE: rtl/isphp_cfg.sv
// APB-style configuration registers of the iron controller.
// Depends on isphp_pkg for the register map, reset values and cfg_t.
module isphp_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [isphp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output isphp_pkg::cfg_t               cfg,
  output isphp_pkg::tgt_load_t          tload
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[isphp_pkg::ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Store register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_setpoint  <= isphp_pkg::RST_START_SETPOINT;
      cfg.standby_temp    <= isphp_pkg::RST_STANDBY_TEMP;
      cfg.max_setpoint    <= isphp_pkg::RST_MAX_SETPOINT;
      cfg.standby_seconds <= isphp_pkg::RST_STANDBY_SECONDS;
      cfg.off_seconds     <= isphp_pkg::RST_OFF_SECONDS;
      cfg.ready_band      <= isphp_pkg::RST_READY_BAND;
      cfg.pwm_period      <= isphp_pkg::RST_PWM_PERIOD;
    end else if (wr) begin
      unique case (idx)
        isphp_pkg::REG_START_SETPOINT:  cfg.start_setpoint  <= pwdata[8:0];
        isphp_pkg::REG_STANDBY_TEMP:    cfg.standby_temp    <= pwdata[8:0];
        isphp_pkg::REG_MAX_SETPOINT:    cfg.max_setpoint    <= pwdata[8:0];
        isphp_pkg::REG_STANDBY_SECONDS: cfg.standby_seconds <= pwdata[11:0];
        isphp_pkg::REG_OFF_SECONDS:     cfg.off_seconds     <= pwdata[11:0];
        isphp_pkg::REG_READY_BAND:      cfg.ready_band      <= pwdata[7:0];
        isphp_pkg::REG_PWM_PERIOD:      cfg.pwm_period      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // A start setpoint write also loads the target, raised to standby if below
  assign tload.load  = wr && (idx == isphp_pkg::REG_START_SETPOINT);
  assign tload.value = (pwdata[8:0] < cfg.standby_temp) ? cfg.standby_temp : pwdata[8:0];

  // Read back
  always_comb begin
    unique case (idx)
      isphp_pkg::REG_START_SETPOINT:  prdata = {23'd0, cfg.start_setpoint};
      isphp_pkg::REG_STANDBY_TEMP:    prdata = {23'd0, cfg.standby_temp};
      isphp_pkg::REG_MAX_SETPOINT:    prdata = {23'd0, cfg.max_setpoint};
      isphp_pkg::REG_STANDBY_SECONDS: prdata = {20'd0, cfg.standby_seconds};
      isphp_pkg::REG_OFF_SECONDS:     prdata = {20'd0, cfg.off_seconds};
      isphp_pkg::REG_READY_BAND:      prdata = {24'd0, cfg.ready_band};
      isphp_pkg::REG_PWM_PERIOD:      prdata = {24'd0, cfg.pwm_period};
      default:                        prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/isphp_step.sv
// Next-state and result logic for one event of the iron controller.
// Depends on isphp_pkg for the event codes, mode codes and state/result types.
module isphp_step (
  input  isphp_pkg::state_t st,
  input  isphp_pkg::cfg_t   cfg,
  input  isphp_pkg::evt_t   ev,
  output isphp_pkg::state_t st_next,
  output isphp_pkg::res_t   res
);

  // Pulse width from setpoint and tip temperature
  function automatic logic [5:0] heat_pulse(input logic [8:0] tgt, input logic [9:0] tip);
    logic [9:0] gap;
    logic [7:0] scaled;
    gap    = {1'b0, tgt} - tip;
    scaled = {3'd0, gap[4:0]} * 8'd5;
    if ({1'b0, tgt} <= tip) begin
      heat_pulse = isphp_pkg::DUTY_MIN;
    end else if (gap > isphp_pkg::GAP_FULL_ON) begin
      heat_pulse = isphp_pkg::DUTY_MAX;
    end else begin
      heat_pulse = scaled[7:2] + isphp_pkg::DUTY_OFFSET;
    end
  endfunction

  function automatic logic in_standby(input isphp_pkg::state_t s, input isphp_pkg::cfg_t c);
    in_standby = s.timer_running && (s.target == c.standby_temp) &&
                 (s.idle_count >= c.standby_seconds);
  endfunction

  logic        restore;
  logic [8:0]  wake_tgt;
  logic [11:0] tick_count;
  logic [7:0]  phase_inc;
  logic [9:0]  diff;
  logic        changed;

  assign restore    = !st.timer_running || in_standby(st, cfg);
  assign wake_tgt   = restore ? st.saved_target : st.target;
  assign tick_count = st.idle_count + 12'd1;
  assign phase_inc  = st.pwm_phase + 8'd1;

  // Apply the event
  always_comb begin
    st_next = st;
    changed = 1'b0;
    unique case (ev.func)
      isphp_pkg::FUNC_TICK: begin
        if (st.timer_running) begin
          st_next.idle_count = tick_count;
          if (tick_count == cfg.standby_seconds) begin
            st_next.saved_target = st.target;
            st_next.target       = cfg.standby_temp;
            changed              = 1'b1;
          end else if (tick_count == cfg.off_seconds) begin
            st_next.target        = 9'd0;
            st_next.idle_count    = 12'd0;
            st_next.timer_running = 1'b0;
            changed               = 1'b1;
          end
        end
      end
      isphp_pkg::FUNC_WAKE: begin
        if (restore) begin
          st_next.target        = st.saved_target;
          st_next.timer_running = 1'b1;
          changed               = 1'b1;
        end
        st_next.idle_count = 12'd0;
      end
      isphp_pkg::FUNC_UP: begin
        st_next.timer_running = 1'b1;
        st_next.target = (wake_tgt < cfg.max_setpoint) ? wake_tgt + 9'd1 : wake_tgt;
        st_next.idle_count = 12'd0;
        changed = 1'b1;
      end
      isphp_pkg::FUNC_DOWN: begin
        st_next.timer_running = 1'b1;
        st_next.target = (wake_tgt > cfg.standby_temp) ? wake_tgt - 9'd1 : wake_tgt;
        st_next.idle_count = 12'd0;
        changed = 1'b1;
      end
      isphp_pkg::FUNC_PWM: begin
        if (phase_inc == cfg.pwm_period) begin
          st_next.pwm_phase = 8'd0;
          st_next.drive     = 1'b1;
        end else begin
          st_next.pwm_phase = phase_inc;
          st_next.drive     = {2'd0, phase_inc} < {4'd0, heat_pulse(st.target, st.tip_temp)};
        end
      end
      isphp_pkg::FUNC_MEASURE: begin
        if (ev.measured_valid) begin
          st_next.tip_temp = ev.measured_temp;
        end
      end
      default: ;
    endcase
  end

  // Report the state after the event
  assign diff = ({1'b0, st_next.target} > st_next.tip_temp) ?
                {1'b0, st_next.target} - st_next.tip_temp :
                st_next.tip_temp - {1'b0, st_next.target};

  assign res.setpoint         = st_next.target;
  assign res.heater_on        = st_next.drive;
  assign res.ready_res        = (diff < {2'd0, cfg.ready_band}) || (diff == 10'd0);
  assign res.setpoint_changed = changed;
  assign res.duty             = heat_pulse(st_next.target, st_next.tip_temp);
  assign res.idle_mode        = !st_next.timer_running     ? isphp_pkg::MODE_OFF :
                                in_standby(st_next, cfg)   ? isphp_pkg::MODE_STANDBY :
                                                             isphp_pkg::MODE_ACTIVE;

endmodule

FILE: rtl/iron_setpoint_sleep_and_heater_pwm_core.sv
// Top level of the iron setpoint, idle timer and heater PWM controller.
// Depends on isphp_pkg, isphp_if (channel interfaces), isphp_cfg and isphp_step.
//
// Usage:
//   evt  - request channel: func selects a one-second tick, wake press, step up,
//          step down, PWM tick or measurement (measured_temp, measured_valid).
//   res  - result channel: one result per request with setpoint, heater_on,
//          ready_res, idle_mode, setpoint_changed and duty after that request.
//   APB  - configuration registers at byte address 4*index; pready is always
//          high; write registers only while no request is in flight.
// Path: a request accepted into the input register is processed into the result
//   register, and its result is offered on res from then on.
// Throughput: one request per cycle while results are taken; the state
//   update for a request is a single pass of compare and add logic between
//   the input register and the result register.
// Reset: rst (synchronous, active high) restores register defaults, sets the
//   setpoint to 180, heater on, timer running, and empties both registers.
// Stall: while res is not taken the result register holds; the input register
//   still accepts one more request, then ready drops until the result moves.
module iron_setpoint_sleep_and_heater_pwm_core (
  input  logic                          clk,
  input  logic                          rst,
  isphp_evt_if.sink                     evt,
  isphp_res_if.source                   res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [isphp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  isphp_pkg::cfg_t      cfg;
  isphp_pkg::tgt_load_t tload;
  isphp_pkg::state_t    st;
  isphp_pkg::state_t    st_next;
  isphp_pkg::evt_t      in_evt;
  isphp_pkg::res_t      step_res;
  isphp_pkg::res_t      out_res;
  logic                 in_valid;
  logic                 out_valid;
  logic                 advance;

  isphp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .tload   (tload)
  );

  isphp_step u_step (
    .st      (st),
    .cfg     (cfg),
    .ev      (in_evt),
    .st_next (st_next),
    .res     (step_res)
  );

  // Move the registered request into the result register when it is free
  assign advance   = in_valid && (!out_valid || res.ready);
  assign evt.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (evt.ready) begin
      in_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      in_evt.func           <= evt.func;
      in_evt.measured_temp  <= evt.measured_temp;
      in_evt.measured_valid <= evt.measured_valid;
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.target        <= isphp_pkg::RST_START_SETPOINT;
      st.saved_target  <= 9'd0;
      st.idle_count    <= 12'd0;
      st.timer_running <= 1'b1;
      st.pwm_phase     <= 8'd0;
      st.tip_temp      <= 10'd0;
      st.drive         <= 1'b1;
    end else if (tload.load) begin
      st.target <= tload.value;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign res.valid            = out_valid;
  assign res.setpoint         = out_res.setpoint;
  assign res.heater_on        = out_res.heater_on;
  assign res.ready_res        = out_res.ready_res;
  assign res.idle_mode        = out_res.idle_mode;
  assign res.setpoint_changed = out_res.setpoint_changed;
  assign res.duty             = out_res.duty;

endmodule

FILE: bench/tb.sv
// Testbench for the iron setpoint, idle timer and heater PWM core.
// It depends on rtl/isphp_pkg.sv, rtl/isphp_if.sv and the core's RTL.
// A scoreboard class predicts every result, and plain tasks drive requests and APB writes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import isphp_pkg::*;

  // Track the iron state, queue the predicted results and check the arrivals
  class setpoint_checker;
    cfg_t        cfg;
    logic [8:0]  target;
    logic [8:0]  saved_target;
    logic [11:0] idle_count;
    logic        timer_on;
    logic [7:0]  pwm_phase;
    logic [9:0]  tip;
    logic        drive;
    res_t        due_q[$];
    int          mismatches;

    function new();
      cfg.start_setpoint  = RST_START_SETPOINT;
      cfg.standby_temp    = RST_STANDBY_TEMP;
      cfg.max_setpoint    = RST_MAX_SETPOINT;
      cfg.standby_seconds = RST_STANDBY_SECONDS;
      cfg.off_seconds     = RST_OFF_SECONDS;
      cfg.ready_band      = RST_READY_BAND;
      cfg.pwm_period      = RST_PWM_PERIOD;
      target       = RST_START_SETPOINT;
      saved_target = '0;
      idle_count   = '0;
      timer_on     = 1'b1;
      pwm_phase    = '0;
      tip          = '0;
      drive        = 1'b1;
      mismatches   = 0;
    endfunction

    function int heat_pulse();
      int gap;
      if (target <= tip) return DUTY_MIN;
      gap = int'(target) - int'(tip);
      if (gap > GAP_FULL_ON) return DUTY_MAX;
      return gap * 25 / 20 + DUTY_OFFSET;
    endfunction

    function bit dozing();
      return timer_on && target == cfg.standby_temp && idle_count >= cfg.standby_seconds;
    endfunction

    // Restore the saved setpoint when the iron is off or sitting at standby
    function void wake_restore();
      if (!timer_on || dozing()) begin
        target   = saved_target;
        timer_on = 1'b1;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_START_SETPOINT: begin
          cfg.start_setpoint = val[8:0];
          target = (val[8:0] < cfg.standby_temp) ? cfg.standby_temp : val[8:0];
        end
        REG_STANDBY_TEMP:    cfg.standby_temp    = val[8:0];
        REG_MAX_SETPOINT:    cfg.max_setpoint    = val[8:0];
        REG_STANDBY_SECONDS: cfg.standby_seconds = val[11:0];
        REG_OFF_SECONDS:     cfg.off_seconds     = val[11:0];
        REG_READY_BAND:      cfg.ready_band      = val[7:0];
        REG_PWM_PERIOD:      cfg.pwm_period      = val[7:0];
        default: ;
      endcase
    endfunction

    // Advance the state by one accepted request and queue its result
    function void note_request(evt_t e);
      res_t r;
      logic changed;
      int   diff;
      changed = 1'b0;
      case (e.func)
        FUNC_TICK: begin
          if (timer_on) begin
            idle_count = idle_count + 12'd1;
            if (idle_count == cfg.standby_seconds) begin
              saved_target = target;
              target       = cfg.standby_temp;
              changed      = 1'b1;
            end else if (idle_count == cfg.off_seconds) begin
              target     = '0;
              idle_count = '0;
              timer_on   = 1'b0;
              changed    = 1'b1;
            end
          end
        end
        FUNC_WAKE: begin
          if (!timer_on || dozing()) changed = 1'b1;
          wake_restore();
          idle_count = '0;
        end
        FUNC_UP: begin
          wake_restore();
          if (target < cfg.max_setpoint) target = target + 9'd1;
          changed    = 1'b1;
          idle_count = '0;
        end
        FUNC_DOWN: begin
          wake_restore();
          if (target > cfg.standby_temp) target = target - 9'd1;
          changed    = 1'b1;
          idle_count = '0;
        end
        FUNC_PWM: begin
          pwm_phase = pwm_phase + 8'd1;
          drive = (pwm_phase < heat_pulse());
          if (pwm_phase == cfg.pwm_period) begin
            pwm_phase = '0;
            drive     = 1'b1;
          end
        end
        FUNC_MEASURE: begin
          if (e.measured_valid) tip = e.measured_temp;
        end
        default: ;
      endcase
      diff = (target > tip) ? int'(target) - int'(tip) : int'(tip) - int'(target);
      r.setpoint         = target;
      r.heater_on        = drive;
      r.ready_res        = (diff < cfg.ready_band) || diff == 0;
      r.idle_mode        = !timer_on ? MODE_OFF : (dozing() ? MODE_STANDBY : MODE_ACTIVE);
      r.setpoint_changed = changed;
      r.duty             = 6'(heat_pulse());
      due_q.push_back(r);
    endfunction

    function void check_field(string what, int exp, int act);
      if (exp != act) begin
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, what, exp, act);
      end
    endfunction

    // Compare an arriving result with the oldest prediction
    function void check_result(res_t got);
      res_t exp;
      if (due_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got setpoint %0d",
                 $time, got.setpoint);
        return;
      end
      exp = due_q.pop_front();
      check_field("setpoint", exp.setpoint, got.setpoint);
      check_field("heater_on", exp.heater_on, got.heater_on);
      check_field("ready_res", exp.ready_res, got.ready_res);
      check_field("idle_mode", exp.idle_mode, got.idle_mode);
      check_field("setpoint_changed", exp.setpoint_changed, got.setpoint_changed);
      check_field("duty", exp.duty, got.duty);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  isphp_evt_if evt_ch ();
  isphp_res_if res_ch ();

  setpoint_checker sb = new();

  int send_gap_pct;
  int stall_pct;
  bit hold_req;

  iron_setpoint_sleep_and_heater_pwm_core dut (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // Drive result ready: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 60;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Observe both channels at the rising edge
  always @(posedge clk) begin
    evt_t req;
    res_t got;
    if (!rst) begin
      if (evt_ch.valid && evt_ch.ready) begin
        req.func           = evt_ch.func;
        req.measured_temp  = evt_ch.measured_temp;
        req.measured_valid = evt_ch.measured_valid;
        sb.note_request(req);
      end
      if (res_ch.valid && res_ch.ready) begin
        got.setpoint         = res_ch.setpoint;
        got.heater_on        = res_ch.heater_on;
        got.ready_res        = res_ch.ready_res;
        got.idle_mode        = res_ch.idle_mode;
        got.setpoint_changed = res_ch.setpoint_changed;
        got.duty             = res_ch.duty;
        sb.check_result(got);
      end
    end
  end

  function automatic evt_t mk(logic [2:0] f, logic [9:0] temp, logic ok);
    evt_t e;
    e.func           = f;
    e.measured_temp  = temp;
    e.measured_valid = ok;
    return e;
  endfunction

  // Pick a request; measurements mostly land near the setpoint
  function automatic evt_t pick_request();
    evt_t e;
    int   pick;
    int   t;
    pick = $urandom_range(99);
    e = mk(FUNC_TICK, 10'($urandom_range(1023)), 1'($urandom_range(1)));
    if (pick < 38) e.func = FUNC_TICK;
    else if (pick < 52) e.func = FUNC_PWM;
    else if (pick < 68) begin
      e.func = FUNC_MEASURE;
      if ($urandom_range(9) < 7) begin
        t = int'(sb.target) + int'($urandom_range(50)) - 25;
        if (t < 0) t = 0;
        e.measured_temp = 10'(t);
      end
    end
    else if (pick < 76) e.func = FUNC_UP;
    else if (pick < 84) e.func = FUNC_DOWN;
    else if (pick < 96) e.func = FUNC_WAKE;
    else e.func = 3'($urandom_range(7, 6));
    return e;
  endfunction

  function automatic cfg_t make_cfg(int kind);
    cfg_t c;
    case (kind)
      0: begin
        c = '{start_setpoint: 9'd0, standby_temp: 9'd0, max_setpoint: 9'd0,
              standby_seconds: 12'd1, off_seconds: 12'd2, ready_band: 8'd0,
              pwm_period: 8'd1};
      end
      1: begin
        c = '{start_setpoint: 9'd511, standby_temp: 9'd511, max_setpoint: 9'd511,
              standby_seconds: 12'd4095, off_seconds: 12'd4095, ready_band: 8'd255,
              pwm_period: 8'd255};
      end
      default: begin
        c.standby_temp    = 9'($urandom_range(300, 100));
        c.start_setpoint  = 9'($urandom_range(511));
        c.max_setpoint    = ($urandom_range(9) == 0) ? 9'($urandom_range(511))
                                                     : c.standby_temp + 9'($urandom_range(40));
        c.standby_seconds = 12'($urandom_range(10, 1));
        c.off_seconds     = 12'($urandom_range(25, 2));
        c.ready_band      = 8'($urandom_range(40));
        c.pwm_period      = 8'($urandom_range(60, 1));
      end
    endcase
    return c;
  endfunction

  // Offer one request after an optional gap and hold it until taken
  task automatic send_request(evt_t e);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      evt_ch.valid <= 1'b0;
      @(negedge clk);
    end
    evt_ch.valid          <= 1'b1;
    evt_ch.func           <= e.func;
    evt_ch.measured_temp  <= e.measured_temp;
    evt_ch.measured_valid <= e.measured_valid;
    do @(posedge clk); while (!evt_ch.ready);
  endtask

  // Drop valid and wait until every predicted result is back
  task automatic settle(int extra);
    @(negedge clk);
    evt_ch.valid <= 1'b0;
    while (sb.due_q.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write standby first so the start setpoint load sees the new floor
  task automatic configure(cfg_t c);
    write_reg(REG_STANDBY_TEMP, 32'(c.standby_temp));
    write_reg(REG_MAX_SETPOINT, 32'(c.max_setpoint));
    write_reg(REG_STANDBY_SECONDS, 32'(c.standby_seconds));
    write_reg(REG_OFF_SECONDS, 32'(c.off_seconds));
    write_reg(REG_READY_BAND, 32'(c.ready_band));
    write_reg(REG_PWM_PERIOD, 32'(c.pwm_period));
    write_reg(REG_START_SETPOINT, 32'(c.start_setpoint));
  endtask

  initial begin
    evt_t e;
    cfg_t c;
    int   n;
    int   burst_left;
    int   burst_cap;
    evt_t directed[$];

    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    evt_ch.valid          = 1'b0;
    evt_ch.func           = FUNC_TICK;
    evt_ch.measured_temp  = '0;
    evt_ch.measured_valid = 1'b0;
    send_gap_pct          = 0;
    stall_pct             = 0;
    hold_req              = 1'b0;
    burst_left            = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Exercise the reset defaults briefly
    repeat (12) send_request(pick_request());
    settle(4);

    // Directed sequence on a narrow window with short timeouts
    send_gap_pct = 8;
    stall_pct    = 8;
    c = '{start_setpoint: 9'd200, standby_temp: 9'd190, max_setpoint: 9'd202,
          standby_seconds: 12'd2, off_seconds: 12'd4, ready_band: 8'd5, pwm_period: 8'd3};
    configure(c);
    directed = '{
      mk(FUNC_MEASURE, 10'd1023, 1'b1), mk(FUNC_MEASURE, 10'd0, 1'b1),
      mk(FUNC_MEASURE, 10'd195, 1'b0),  mk(FUNC_MEASURE, 10'd199, 1'b1),
      mk(FUNC_MEASURE, 10'd180, 1'b1),  mk(FUNC_MEASURE, 10'd179, 1'b1),
      mk(FUNC_PWM, 10'd0, 1'b0), mk(FUNC_PWM, 10'd0, 1'b0),
      mk(FUNC_PWM, 10'd0, 1'b0), mk(FUNC_PWM, 10'd0, 1'b0),
      mk(FUNC_UP, 10'd0, 1'b0), mk(FUNC_UP, 10'd0, 1'b0), mk(FUNC_UP, 10'd0, 1'b0),
      mk(FUNC_DOWN, 10'd0, 1'b0),
      mk(FUNC_TICK, 10'd0, 1'b0), mk(FUNC_TICK, 10'd0, 1'b0), mk(FUNC_WAKE, 10'd0, 1'b0),
      mk(FUNC_TICK, 10'd0, 1'b0), mk(FUNC_TICK, 10'd0, 1'b0), mk(FUNC_UP, 10'd0, 1'b0),
      mk(FUNC_TICK, 10'd0, 1'b0), mk(FUNC_TICK, 10'd0, 1'b0),
      mk(FUNC_TICK, 10'd0, 1'b0), mk(FUNC_TICK, 10'd0, 1'b0),
      mk(FUNC_TICK, 10'd1023, 1'b1), mk(FUNC_DOWN, 10'd0, 1'b0),
      mk(3'd6, 10'd1023, 1'b1), mk(3'd7, 10'd512, 1'b0),
      mk(FUNC_MEASURE, 10'd1023, 1'b1)
    };
    foreach (directed[i]) send_request(directed[i]);
    settle(4);

    // Random phases: extremes first, then random settings, each with its own idling
    for (int p = 0; p < 6; p++) begin
      configure(make_cfg(p));
      case (p)
        0, 4: begin send_gap_pct = 0;  stall_pct = 0;  n = (p == 0) ? 150 : 250; end
        1, 5: begin send_gap_pct = 81; stall_pct = 0;  n = (p == 1) ? 150 : 200; end
        2:    begin send_gap_pct = 0;  stall_pct = 81; n = 300; end
        default: begin send_gap_pct = 8; stall_pct = 8; n = 300; end
      endcase
      burst_cap = (sb.cfg.off_seconds > 38) ? 40 : int'(sb.cfg.off_seconds) + 2;
      for (int i = 0; i < n; i++) begin
        // Runs of ticks carry the idle timer into standby and off
        if (burst_left > 0) begin
          e = mk(FUNC_TICK, 10'($urandom_range(1023)), 1'($urandom_range(1)));
          burst_left--;
        end else if ($urandom_range(99) < 8) begin
          burst_left = $urandom_range(burst_cap, 1);
          e = mk(FUNC_TICK, 10'($urandom_range(1023)), 1'($urandom_range(1)));
        end else begin
          e = pick_request();
        end
        if (p == 2 && i == 20) hold_req = 1'b1;
        if (p == 3 && i == n / 2) settle(0);
        send_request(e);
      end
      burst_left = 0;
      settle(4);
    end

    stall_pct = 0;
    settle(0);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
